FILE: rtl/stpd_pkg.sv
// ----------------------------------------------------------------------------
// stpd_pkg
// Types, codes and speed tables shared by the stepper profile driver.
// ----------------------------------------------------------------------------
package stpd_pkg;

  localparam int POSITION_BITS = 10;

  localparam logic [1:0] FUNC_MOVE = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_ZERO = 2'd2;

  localparam logic [1:0] CFG_DECEL_STEPS     = 2'd0;
  localparam logic [1:0] CFG_TOP_SPEED_LEVEL = 2'd1;
  localparam logic [1:0] CFG_TRAVEL_STEPS    = 2'd2;
  localparam logic [1:0] CFG_ZERO_DELAY_US   = 2'd3;

  typedef struct packed {
    logic [1:0]               func;
    logic [POSITION_BITS-1:0] target;
  } stpd_cmd_t;

  typedef struct packed {
    logic                     step_valid;
    logic [3:0]               coil_pattern;
    logic [15:0]              delay_us;
    logic [POSITION_BITS-1:0] position;
    logic                     busy_res;
    logic                     move_done;
  } stpd_res_t;

  typedef struct packed {
    logic [7:0]               decel_steps;
    logic [2:0]               top_speed_level;
    logic [POSITION_BITS-1:0] travel_steps;
    logic [15:0]              zero_delay_us;
  } stpd_cfg_t;

  function automatic logic [3:0] coil_of(input logic [2:0] ph);
    logic [3:0] c;
    unique case (ph)
      3'd0:    c = 4'h9;
      3'd1:    c = 4'h1;
      3'd2:    c = 4'h7;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'hE;
      3'd5:    c = 4'h8;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] level_delay(input logic [3:0] lv);
    logic [15:0] d;
    unique case (lv)
      4'd0:    d = 16'd1750;
      4'd1:    d = 16'd1149;
      4'd2:    d = 16'd926;
      4'd3:    d = 16'd794;
      4'd4:    d = 16'd709;
      4'd5:    d = 16'd666;
      default: d = 16'd450;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] level_count(input logic [3:0] lv);
    logic [2:0] n;
    if (lv < 4'd5) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

endpackage

FILE: rtl/stpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// stpd_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module stpd_cfg_regs import stpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output stpd_cfg_t   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decel_steps     <= 8'd23;
      cfg.top_speed_level <= 3'd6;
      cfg.travel_steps    <= POSITION_BITS'(945);
      cfg.zero_delay_us   <= 16'd1900;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DECEL_STEPS:     cfg.decel_steps     <= cfg_data[7:0];
        CFG_TOP_SPEED_LEVEL: cfg.top_speed_level <= cfg_data[2:0];
        CFG_TRAVEL_STEPS:    cfg.travel_steps    <= cfg_data[POSITION_BITS-1:0];
        CFG_ZERO_DELAY_US:   cfg.zero_delay_us   <= cfg_data;
      endcase
    end
  end

endmodule

FILE: rtl/stpd_profile.sv
// ----------------------------------------------------------------------------
// stpd_profile
// Motion state registers and the combinational step and profile update.
// ----------------------------------------------------------------------------
module stpd_profile import stpd_pkg::*; #(
  parameter int PHASES       = 6,
  parameter int SPEED_LEVELS = 7
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      update,
  input  stpd_cfg_t cfg,
  input  stpd_cmd_t cmd,
  output stpd_res_t res
);

  localparam int PW = $clog2(PHASES);
  localparam int LW = $clog2(SPEED_LEVELS);

  logic [POSITION_BITS-1:0] position_reg, position_reg_next;
  logic [PW-1:0]            phase, phase_next;
  logic [POSITION_BITS-1:0] steps_left, steps_left_next;
  logic [LW-1:0]            speed_level, speed_level_next;
  logic [2:0]               steps_at_level, steps_at_level_next;
  logic [15:0]              current_delay, current_delay_next;
  logic                     moving_up, moving_up_next;
  logic                     zeroing, zeroing_next;

  logic [LW-1:0]            top;
  logic [POSITION_BITS-1:0] tgt;
  logic [PW-1:0]            phase_up, phase_dn;

  always_comb begin
    if ({1'b0, cfg.top_speed_level} > 4'(SPEED_LEVELS - 1)) begin
      top = LW'(SPEED_LEVELS - 1);
    end else begin
      top = LW'(cfg.top_speed_level);
    end
    tgt      = (cmd.target > cfg.travel_steps) ? cfg.travel_steps : cmd.target;
    phase_up = (phase == PW'(PHASES - 1)) ? '0 : phase + 1'b1;
    phase_dn = (phase == '0) ? PW'(PHASES - 1) : phase - 1'b1;
  end

  always_comb begin
    position_reg_next   = position_reg;
    phase_next          = phase;
    steps_left_next     = steps_left;
    speed_level_next    = speed_level;
    steps_at_level_next = steps_at_level;
    current_delay_next  = current_delay;
    moving_up_next      = moving_up;
    zeroing_next        = zeroing;
    res                 = '0;

    unique case (cmd.func)
      FUNC_MOVE: begin
        zeroing_next        = 1'b0;
        speed_level_next    = '0;
        current_delay_next  = level_delay(4'd0);
        steps_at_level_next = 3'd0;
        if (position_reg < tgt) begin
          moving_up_next  = 1'b1;
          steps_left_next = tgt - position_reg;
        end else begin
          moving_up_next  = 1'b0;
          steps_left_next = position_reg - tgt;
        end
      end
      FUNC_ZERO: begin
        speed_level_next    = '0;
        steps_at_level_next = 3'd0;
        moving_up_next      = 1'b0;
        if (cfg.travel_steps == '0) begin
          zeroing_next      = 1'b0;
          steps_left_next   = '0;
          position_reg_next = '0;
          phase_next        = '0;
          res.move_done     = 1'b1;
        end else begin
          zeroing_next    = 1'b1;
          steps_left_next = cfg.travel_steps;
        end
      end
      FUNC_TICK: begin
        if (steps_left != '0) begin
          res.step_valid   = 1'b1;
          res.coil_pattern = coil_of(3'(phase));
          steps_left_next  = steps_left - 1'b1;
          if (zeroing) begin
            phase_next   = phase_dn;
            res.delay_us = cfg.zero_delay_us;
            if (steps_left_next == '0) begin
              position_reg_next = '0;
              phase_next        = '0;
              zeroing_next      = 1'b0;
              res.move_done     = 1'b1;
            end
          end else begin
            // decelerate near the end, otherwise climb towards the top level
            if (steps_left <= POSITION_BITS'(cfg.decel_steps)) begin
              if (steps_at_level == 3'd0) begin
                if (speed_level != '0) begin
                  speed_level_next = speed_level - 1'b1;
                end
                current_delay_next  = level_delay(4'(speed_level_next));
                steps_at_level_next = level_count(4'(speed_level_next));
              end
            end else if (steps_at_level == 3'd0 && speed_level < top) begin
              speed_level_next    = speed_level + 1'b1;
              current_delay_next  = level_delay(4'(speed_level_next));
              steps_at_level_next = level_count(4'(speed_level_next));
            end
            res.delay_us = current_delay_next;
            if (steps_at_level_next != 3'd0) begin
              steps_at_level_next = steps_at_level_next - 1'b1;
            end
            phase_next        = moving_up ? phase_up : phase_dn;
            position_reg_next = moving_up ? position_reg + 1'b1 : position_reg - 1'b1;
            res.move_done     = (steps_left_next == '0);
          end
        end
      end
      default: ;
    endcase

    res.position = position_reg_next;
    res.busy_res = (steps_left_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_reg   <= '0;
      phase          <= '0;
      steps_left     <= '0;
      speed_level    <= '0;
      steps_at_level <= 3'd0;
      current_delay  <= 16'd0;
      moving_up      <= 1'b0;
      zeroing        <= 1'b0;
    end else if (update) begin
      position_reg   <= position_reg_next;
      phase          <= phase_next;
      steps_left     <= steps_left_next;
      speed_level    <= speed_level_next;
      steps_at_level <= steps_at_level_next;
      current_delay  <= current_delay_next;
      moving_up      <= moving_up_next;
      zeroing        <= zeroing_next;
    end
  end

endmodule

FILE: rtl/stepper_accel_profile_driver.sv
// ----------------------------------------------------------------------------
// stepper_accel_profile_driver
// Six-phase gauge stepper driver with a trapezoidal speed profile.
// ----------------------------------------------------------------------------
// Every command (move, step tick or zero sweep) yields exactly one result.
// A command is held in an input register, the profile update is
// combinational and the result sits in an output register. One command is
// taken every cycle unless a stalled result holds it, and a stalled result
// stalls the input only once the input register is also full.
// Configuration is written through a plain write port; the user must write
// it only while idle, as the block itself does not enforce this.
module stepper_accel_profile_driver import stpd_pkg::*; #(
  parameter int PHASES       = 6,
  parameter int SPEED_LEVELS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  stpd_cmd_t   cmd,
  output logic        res_valid,
  input  logic        res_stall,
  output stpd_res_t   res,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  stpd_cfg_t cfg;
  stpd_cmd_t cmd_q;
  stpd_res_t res_next;
  logic      cmd_full;
  logic      advance;

  assign advance   = cmd_full && (!res_valid || !res_stall);
  assign cmd_stall = cmd_full && !advance;

  stpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  stpd_profile #(
    .PHASES       (PHASES),
    .SPEED_LEVELS (SPEED_LEVELS)
  ) u_profile (
    .clk    (clk),
    .rst    (rst),
    .update (advance),
    .cfg    (cfg),
    .cmd    (cmd_q),
    .res    (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_full  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        cmd_full <= 1'b1;
      end else if (advance) begin
        cmd_full <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      cmd_q <= cmd;
    end
    if (advance) begin
      res <= res_next;
    end
  end

endmodule

FILE: rtl/stpd_checker.sv
// ----------------------------------------------------------------------------
// stpd_checker
// Port-level checks on the stepper profile driver, bound to the top level.
// ----------------------------------------------------------------------------
module stpd_checker import stpd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_stall,
  input stpd_cmd_t   cmd,
  input logic        res_valid,
  input logic        res_stall,
  input stpd_res_t   res,
  input logic        cfg_write,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_data
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result shown straight after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.move_done |-> !res.busy_res)
    else $error("move finished but still busy");

  a_no_step_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.step_valid |-> res.coil_pattern == 4'd0 && res.delay_us == 16'd0)
    else $error("coil or delay driven without a step");

endmodule

bind stepper_accel_profile_driver stpd_checker u_stpd_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res),
  .cfg_write (cfg_write),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
